// ----- hdl/paoc_pkg.sv -----
// ----------------------------------------------------------------------------
// paoc_pkg
// shared types and constants for the periodic atom overlap checker
// ----------------------------------------------------------------------------
package paoc_pkg;

	localparam int MaxPlaced   = 4096;
	localparam int MaxMol      = 256;
	localparam int PlAw        = $clog2(MaxPlaced);
	localparam int MolAw       = $clog2(MaxMol);
	localparam int PcW         = PlAw + 1;
	localparam int CcW         = MolAw + 1;
	localparam int CoordW      = 20;
	localparam int BoxW        = 19;
	localparam int TolW        = 32;
	localparam int QDepth      = 2;

	localparam logic [1:0] REG_BOX_X = 2'd0;
	localparam logic [1:0] REG_BOX_Y = 2'd1;
	localparam logic [1:0] REG_BOX_Z = 2'd2;
	localparam logic [1:0] REG_TOL   = 2'd3;

	localparam logic [1:0] ST_ACCEPT = 2'd0;
	localparam logic [1:0] ST_OVLP   = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_LARGE  = 2'd3;

	typedef struct packed {
		logic                     clr;
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic [BoxW-1:0] bx;
		logic [BoxW-1:0] by;
		logic [BoxW-1:0] bz;
		logic [TolW-1:0] tol;
	} cfg_t;

	// one minimum-image fold: at most two steps each way
	function automatic logic signed [22:0] fold(input logic signed [22:0] d,
		input logic [BoxW-1:0] len);
		logic signed [22:0] l;
		logic signed [22:0] r;
		begin
			l = signed'({4'd0, len});
			r = d;
			if ((r <<< 1) > l) r = r - l;
			if ((r <<< 1) > l) r = r - l;
			if ((r <<< 1) < -l) r = r + l;
			if ((r <<< 1) < -l) r = r + l;
			return r;
		end
	endfunction

endpackage

// ----- hdl/paoc_front.sv -----
// ----------------------------------------------------------------------------
// paoc_front
// input queue between the stream slave and the checker engine
// ----------------------------------------------------------------------------
module paoc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_valid,
	output logic                   s_ready,
	input  paoc_pkg::item_t        s_item,
	output logic                   q_valid,
	input  logic                   q_pop,
	output paoc_pkg::item_t        q_item
);
	import paoc_pkg::*;

	item_t          mem_q [QDepth];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push;

	assign s_ready = (cnt_q != 2'(QDepth));
	assign push    = s_valid && s_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= s_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop && q_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end
endmodule

// ----- hdl/paoc_engine.sv -----
// ----------------------------------------------------------------------------
// paoc_engine
// scans the placed store for each atom, gathers the molecule, commits it if accepted
// ----------------------------------------------------------------------------
module paoc_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  paoc_pkg::cfg_t         cfg,
	input  logic                   q_valid,
	output logic                   q_pop,
	input  paoc_pkg::item_t        q_item,
	output logic                   r_valid,
	input  logic                   r_ready,
	output logic [1:0]             r_status,
	output logic [12:0]            r_stored
);
	import paoc_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_DRN  = 6'b000100,
		S_DEC  = 6'b001000,
		S_COPY = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q;

	logic [3*CoordW-1:0] pmem [MaxPlaced];
	logic [3*CoordW-1:0] cmem [MaxMol];

	logic [PcW-1:0]   pcount_q;
	logic [CcW-1:0]   ccount_q;
	logic             ovl_q;
	item_t            cur_q;
	logic [PcW-1:0]   idx_q;
	logic [CcW-1:0]   cidx_q;
	logic [3*CoordW-1:0] prd_s1, crd_q;
	logic             v_s1, v_s2, v_s3;
	logic signed [22:0] dx_s2, dy_s2, dz_s2;
	logic [45:0]      sx_s3, sy_s3, sz_s3;
	logic [1:0]       dec_q;
	logic [1:0]       status_q;
	logic [12:0]      stored_q;
	logic             rv_q;
	logic             cvld_q;
	logic [47:0]      d2;

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign r_valid  = rv_q;
	assign r_status = status_q;
	assign r_stored = stored_q;

	assign d2 = 48'(sx_s3) + 48'(sy_s3) + 48'(sz_s3);

	always_ff @(posedge clk) begin
		prd_s1 <= pmem[idx_q[PlAw-1:0]];
		crd_q  <= cmem[cidx_q[MolAw-1:0]];
		dx_s2 <= fold(23'(cur_q.x) - 23'(signed'(prd_s1[3*CoordW-1 -: CoordW])), cfg.bx);
		dy_s2 <= fold(23'(cur_q.y) - 23'(signed'(prd_s1[2*CoordW-1 -: CoordW])), cfg.by);
		dz_s2 <= fold(23'(cur_q.z) - 23'(signed'(prd_s1[CoordW-1:0])), cfg.bz);
		sx_s3 <= 46'(dx_s2 * dx_s2);
		sy_s3 <= 46'(dy_s2 * dy_s2);
		sz_s3 <= 46'(dz_s2 * dz_s2);
		if (state_q == S_IDLE && q_valid && !q_item.clr && ccount_q < CcW'(MaxMol))
			cmem[ccount_q[MolAw-1:0]] <= {q_item.x, q_item.y, q_item.z};
		if (cvld_q)
			pmem[PlAw'(pcount_q + PcW'(cidx_q) - PcW'(1))] <= crd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pcount_q <= '0;
			ccount_q <= '0;
			ovl_q    <= 1'b0;
			idx_q    <= '0;
			cidx_q   <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			rv_q     <= 1'b0;
			cvld_q   <= 1'b0;
			dec_q    <= ST_ACCEPT;
			status_q <= ST_ACCEPT;
			stored_q <= '0;
			cur_q    <= '0;
		end else begin
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s1   <= 1'b0;
			cvld_q <= 1'b0;
			if (v_s3 && d2 < 48'(cfg.tol)) ovl_q <= 1'b1;
			if (rv_q && r_ready) rv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_q <= q_item;
						idx_q <= '0;
						if (q_item.clr) begin
							pcount_q <= '0;
							ccount_q <= '0;
							ovl_q    <= 1'b0;
						end else begin
							if (ccount_q <= CcW'(MaxMol)) ccount_q <= ccount_q + 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (idx_q >= pcount_q || ovl_q) state_q <= S_DRN;
					else begin
						idx_q <= idx_q + 1'b1;
						v_s1  <= 1'b1;
					end
				end
				S_DRN: begin
					if (!v_s1 && !v_s2 && !v_s3)
						state_q <= cur_q.last ? S_DEC : S_IDLE;
				end
				S_DEC: begin
					cidx_q <= '0;
					if (ccount_q > CcW'(MaxMol)) begin
						dec_q   <= ST_LARGE;
						state_q <= S_OUT;
					end else if (ovl_q) begin
						dec_q   <= ST_OVLP;
						state_q <= S_OUT;
					end else if (32'(pcount_q) + 32'(ccount_q) > 32'(MaxPlaced)) begin
						dec_q   <= ST_FULL;
						state_q <= S_OUT;
					end else begin
						dec_q   <= ST_ACCEPT;
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					if (cidx_q < ccount_q) begin
						cidx_q <= cidx_q + 1'b1;
						cvld_q <= 1'b1;
					end else if (!cvld_q) begin
						pcount_q <= pcount_q + PcW'(ccount_q);
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (!rv_q) begin
						rv_q     <= 1'b1;
						status_q <= dec_q;
						stored_q <= 13'(pcount_q);
						ccount_q <= '0;
						ovl_q    <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/periodic_atom_overlap_checker_top.sv -----
// ----------------------------------------------------------------------------
// periodic_atom_overlap_checker_top
// minimum-image overlap check of candidate molecules against a placed store
// ----------------------------------------------------------------------------
// usage
//   s_axis: one atom per beat; tuser selects clear, tlast marks the final atom
//   m_axis: one decision beat per final atom (status, atoms held)
//   cfg: write enable, index and data, written while the block is idle
// scan
//   one placed atom is read from the store memory per cycle and runs through
//   fold and square registers and a combinational sum and tolerance compare;
//   the scan of an atom ends early once an overlap is flagged
//   an accepted final atom is followed by the store append, a rejected one
//   is not
// reset
//   both counts and the overlap flag clear, registers take their defaults
//   the store memories are not cleared
// stall
//   a two-entry queue takes atoms while the decision register waits on
//   m_axis_tready; the engine holds a new decision until the old one leaves
// ----------------------------------------------------------------------------
module periodic_atom_overlap_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // pos_x, pos_y, pos_z, zero pad
	input  logic        s_axis_tuser,   // mode
	input  logic        s_axis_tlast,   // last_atom
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // status, atoms_stored, zero pad
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import paoc_pkg::*;

	cfg_t  cfg_q;
	item_t s_item, q_item;
	logic  q_valid, q_pop;
	logic [1:0]  st;
	logic [12:0] cnt;

	assign s_item.clr  = s_axis_tuser;
	assign s_item.x    = s_axis_tdata[19:0];
	assign s_item.y    = s_axis_tdata[39:20];
	assign s_item.z    = s_axis_tdata[59:40];
	assign s_item.last = s_axis_tlast;
	assign m_axis_tdata = {1'b0, cnt, st};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bx  <= 19'd256;
			cfg_q.by  <= 19'd256;
			cfg_q.bz  <= 19'd256;
			cfg_q.tol <= 32'd262144;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_X: cfg_q.bx  <= cfg_data[BoxW-1:0];
				REG_BOX_Y: cfg_q.by  <= cfg_data[BoxW-1:0];
				REG_BOX_Z: cfg_q.bz  <= cfg_data[BoxW-1:0];
				REG_TOL:   cfg_q.tol <= cfg_data;
				default: ;
			endcase
		end
	end

	paoc_front u_front (
		.clk, .arst_n,
		.s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_item,
		.q_valid, .q_pop, .q_item
	);

	paoc_engine u_engine (
		.clk, .arst_n, .cfg(cfg_q),
		.q_valid, .q_pop, .q_item,
		.r_valid(m_axis_tvalid), .r_ready(m_axis_tready),
		.r_status(st), .r_stored(cnt)
	);
endmodule

// ----- hdl/paoc_checker.sv -----
// ----------------------------------------------------------------------------
// paoc_checker
// port-level checks on the overlap checker
// ----------------------------------------------------------------------------
module paoc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("decision changed while stalled");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[15])
		else $error("pad bit set");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[14:2] <= 13'd4096)
		else $error("stored count out of range");
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == 2'd0 |-> m_axis_tdata[14:2] != 13'd0)
		else $error("accepted molecule with empty store");
endmodule

bind periodic_atom_overlap_checker_top paoc_checker u_paoc_checker (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
